// ----- rtl/iteration_to_hsv_color_top_assert.svh -----
// Assertion macros for the iteration to HSV color block.
`ifndef ITERATION_TO_HSV_COLOR_TOP_ASSERT_SVH
`define ITERATION_TO_HSV_COLOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define ITHSV_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ithsv assertion failed");

// Next-cycle implication, disabled in reset.
`define ITHSV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ithsv assertion failed");

`endif

// ----- rtl/ithsv_pkg.sv -----
// Package: shared constants, types and codes of the iteration to HSV color block.
package ithsv_pkg;

    localparam int COUNT_BITS_DEF    = 16;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int LIMIT_BITS     = 16;
    localparam int MULT_BITS      = 4;
    localparam int CHAN_BITS      = 8;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_ITERATION_LIMIT = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HUE_MULTIPLIER  = 2'd1;

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 16'd64;
    localparam logic [MULT_BITS-1:0]  MULT_RESET  = 4'd1;

    // hue scale 120 * multiplier, up to 1800
    localparam int HUE_SPAN      = 120;
    localparam int SCALE_BITS    = 11;
    // hue in degrees, 8 fraction bits, below 1800 * 256
    localparam int HUE_FRAC_BITS = 8;
    localparam int HUE_BITS      = 19;
    // 60 degrees in hue units = 15 << 10
    localparam int SECTOR_SPAN   = 15360;
    localparam int SECTOR_SHIFT  = 10;
    localparam int SECTOR_DIV    = 15;
    localparam int REM_BITS      = 14;
    localparam int SEC_NUM_BITS  = 5;
    // x / 15 ~ (x * 273) >> 12, low by at most one
    localparam int RECIP_15      = 273;
    localparam int RECIP_BITS    = 9;
    localparam int RECIP_SHIFT   = 12;
    // 0.8 * 255
    localparam int VALUE_MAX     = 204;

    typedef enum logic [2:0] {
        SECTOR_0 = 3'd0,
        SECTOR_1 = 3'd1,
        SECTOR_2 = 3'd2,
        SECTOR_3 = 3'd3,
        SECTOR_4 = 3'd4,
        SECTOR_5 = 3'd5
    } sector_t;

    typedef struct packed {
        logic valid;
        logic black;
    } ctl_t;

endpackage

// ----- rtl/ithsv_count_if.sv -----
// Interface: iteration count input channel.
interface ithsv_count_if #(parameter int COUNT_BITS = ithsv_pkg::COUNT_BITS_DEF);
    logic                  valid;
    logic                  ready;
    logic [COUNT_BITS-1:0] iteration_count;

    modport source (output valid, output iteration_count, input ready);
    modport sink   (input valid, input iteration_count, output ready);
endinterface

// ----- rtl/ithsv_pixel_if.sv -----
// Interface: RGB pixel output channel.
interface ithsv_pixel_if;
    import ithsv_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CHAN_BITS-1:0] red;
    logic [CHAN_BITS-1:0] green;
    logic [CHAN_BITS-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ----- rtl/ithsv_cfg_if.sv -----
// Interface: configuration register write channel.
interface ithsv_cfg_if;
    import ithsv_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/ithsv_divider.sv -----
// Pipelined restoring divider: t = (count << FRACTION_BITS) / limit, one bit per stage.
module ithsv_divider #(
    parameter int COUNT_BITS    = ithsv_pkg::COUNT_BITS_DEF,
    parameter int FRACTION_BITS = ithsv_pkg::FRACTION_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [COUNT_BITS-1:0]           count,
    input  logic [ithsv_pkg::LIMIT_BITS-1:0] limit,
    output ithsv_pkg::ctl_t                 out_ctl,
    output logic [FRACTION_BITS-1:0]        quotient
);
    import ithsv_pkg::*;

    localparam int CMP_BITS = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;

    ctl_t                     ctl_reg [FRACTION_BITS];
    logic [LIMIT_BITS-1:0]    rem_reg [FRACTION_BITS];
    logic [FRACTION_BITS-1:0] quo_reg [FRACTION_BITS];

    ctl_t                  ctl_in;
    logic [LIMIT_BITS-1:0] rem_in;

    assign ctl_in.valid = in_valid;
    assign ctl_in.black = CMP_BITS'(count) >= CMP_BITS'(limit);
    // count < limit whenever the pixel is not black, so it fits the remainder
    assign rem_in       = LIMIT_BITS'(count);

    genvar i;
    generate
        for (i = 0; i < FRACTION_BITS; i++)
        begin : g_stage
            ctl_t                     ctl_prev;
            logic [LIMIT_BITS-1:0]    rem_prev;
            logic [FRACTION_BITS-1:0] quo_prev;
            logic [LIMIT_BITS:0]      shifted;
            logic                     take;
            logic [LIMIT_BITS-1:0]    rem_next;
            logic [FRACTION_BITS-1:0] quo_next;

            if (i == 0)
            begin : g_first
                assign ctl_prev = ctl_in;
                assign rem_prev = rem_in;
                assign quo_prev = '0;
            end
            else
            begin : g_rest
                assign ctl_prev = ctl_reg[i-1];
                assign rem_prev = rem_reg[i-1];
                assign quo_prev = quo_reg[i-1];
            end

            assign shifted  = {rem_prev, 1'b0};
            assign take     = shifted >= {1'b0, limit};
            assign rem_next = LIMIT_BITS'(take ? (shifted - {1'b0, limit}) : shifted);
            assign quo_next = {quo_prev[FRACTION_BITS-2:0], take};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    ctl_reg[i] <= '0;
                end
                else if (en)
                begin
                    ctl_reg[i] <= ctl_prev;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i] <= rem_next;
                    quo_reg[i] <= quo_next;
                end
            end
        end
    endgenerate

    assign out_ctl  = ctl_reg[FRACTION_BITS-1];
    assign quotient = quo_reg[FRACTION_BITS-1];

endmodule

// ----- rtl/ithsv_hue.sv -----
// Hue pipeline: hue = t * 120 * multiplier, split into sector and weight.
module ithsv_hue #(
    parameter int FRACTION_BITS = ithsv_pkg::FRACTION_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  ithsv_pkg::ctl_t                in_ctl,
    input  logic [FRACTION_BITS-1:0]       t,
    input  logic [ithsv_pkg::MULT_BITS-1:0] mult,
    output ithsv_pkg::ctl_t                out_ctl,
    output logic [FRACTION_BITS-1:0]       t_out,
    output ithsv_pkg::sector_t             sector,
    output logic [ithsv_pkg::REM_BITS-1:0] weight
);
    import ithsv_pkg::*;

    localparam int PROD_BITS = FRACTION_BITS + SCALE_BITS;
    localparam int X_BITS    = HUE_BITS - SECTOR_SHIFT;
    localparam int RP_BITS   = X_BITS + RECIP_BITS;
    localparam int POS_BITS  = REM_BITS - SECTOR_SHIFT;

    // stage 1: scale
    logic [SCALE_BITS-1:0]    scale;
    logic [PROD_BITS-1:0]     prod_next;
    ctl_t                     ctl1_reg;
    logic [FRACTION_BITS-1:0] t1_reg;
    logic [PROD_BITS-1:0]     prod_reg;

    assign scale     = SCALE_BITS'(mult) * SCALE_BITS'(HUE_SPAN);
    assign prod_next = PROD_BITS'(t) * PROD_BITS'(scale);

    // stage 2: hue and sector estimate
    logic [HUE_BITS-1:0]     hue;
    logic [X_BITS-1:0]       hue_hi;
    logic [RP_BITS-1:0]      recip_prod;
    logic [SEC_NUM_BITS-1:0] qest_next;
    ctl_t                     ctl2_reg;
    logic [FRACTION_BITS-1:0] t2_reg;
    logic [X_BITS-1:0]        hue_hi_reg;
    logic [SECTOR_SHIFT-1:0]  hue_lo_reg;
    logic [SEC_NUM_BITS-1:0]  qest_reg;

    assign hue        = prod_reg[FRACTION_BITS - HUE_FRAC_BITS +: HUE_BITS];
    assign hue_hi     = hue[HUE_BITS-1:SECTOR_SHIFT];
    assign recip_prod = RP_BITS'(hue_hi) * RP_BITS'(RECIP_15);
    assign qest_next  = recip_prod[RECIP_SHIFT +: SEC_NUM_BITS];

    // stage 3: correct the estimate, sector and weight
    logic [X_BITS-1:0]       diff;
    logic                    fix;
    logic [SEC_NUM_BITS-1:0] sec_num;
    logic [X_BITS-1:0]       pos;
    logic [REM_BITS-1:0]     rem;
    sector_t                 sector_next;
    logic [REM_BITS-1:0]     weight_next;
    ctl_t                     ctl3_reg;
    logic [FRACTION_BITS-1:0] t3_reg;
    sector_t                  sector_reg;
    logic [REM_BITS-1:0]      weight_reg;

    assign diff    = X_BITS'(hue_hi_reg - X_BITS'(qest_reg) * X_BITS'(SECTOR_DIV));
    assign fix     = diff >= X_BITS'(SECTOR_DIV);
    assign sec_num = qest_reg + SEC_NUM_BITS'(fix);
    assign pos     = fix ? X_BITS'(diff - X_BITS'(SECTOR_DIV)) : diff;
    assign rem     = {pos[POS_BITS-1:0], hue_lo_reg};

    // every sector from five up maps to the last one; parity still picks the weight
    assign sector_next = (sec_num >= SEC_NUM_BITS'(SECTOR_5)) ? SECTOR_5
                                                              : sector_t'(sec_num[2:0]);
    assign weight_next = sec_num[0] ? REM_BITS'(REM_BITS'(SECTOR_SPAN) - rem) : rem;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end
        else if (en)
        begin
            ctl1_reg <= in_ctl;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg     <= t;
            prod_reg   <= prod_next;
            t2_reg     <= t1_reg;
            hue_hi_reg <= hue_hi;
            hue_lo_reg <= hue[SECTOR_SHIFT-1:0];
            qest_reg   <= qest_next;
            t3_reg     <= t2_reg;
            sector_reg <= sector_next;
            weight_reg <= weight_next;
        end
    end

    assign out_ctl = ctl3_reg;
    assign t_out   = t3_reg;
    assign sector  = sector_reg;
    assign weight  = weight_reg;

endmodule

// ----- rtl/ithsv_channel.sv -----
// Channel pipeline: min and mid values, rounding and sector channel order.
module ithsv_channel #(
    parameter int FRACTION_BITS = ithsv_pkg::FRACTION_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  ithsv_pkg::ctl_t                 in_ctl,
    input  logic [FRACTION_BITS-1:0]        t,
    input  ithsv_pkg::sector_t              sector,
    input  logic [ithsv_pkg::REM_BITS-1:0]  weight,
    output logic                            out_valid,
    output logic [ithsv_pkg::CHAN_BITS-1:0] red,
    output logic [ithsv_pkg::CHAN_BITS-1:0] green,
    output logic [ithsv_pkg::CHAN_BITS-1:0] blue
);
    import ithsv_pkg::*;

    localparam int TU_BITS = FRACTION_BITS + REM_BITS;
    localparam int LO_BITS = FRACTION_BITS + CHAN_BITS;
    localparam int NW      = FRACTION_BITS + CHAN_BITS + REM_BITS;
    localparam int MS_BITS = NW - FRACTION_BITS - SECTOR_SHIFT;
    localparam int RP_BITS = MS_BITS + RECIP_BITS;

    localparam logic [LO_BITS-1:0] LO_HALF = LO_BITS'(1) << (FRACTION_BITS - 1);
    // (204 * 2^F + 2^(F-1)) * 15360: the mid numerator at t = 0, plus rounding
    localparam logic [NW-1:0] K_NUM =
        NW'(((64'(VALUE_MAX) << FRACTION_BITS) + (64'd1 << (FRACTION_BITS - 1)))
            * 64'(SECTOR_SPAN));

    // stage 1: t * (15360 - w), rounded min
    logic [REM_BITS-1:0]      u;
    logic [TU_BITS-1:0]       tu_next;
    logic [FRACTION_BITS:0]   tc;
    logic [LO_BITS-1:0]       lo_sum;
    ctl_t                     ctl1_reg;
    logic [TU_BITS-1:0]       tu_reg;
    logic [CHAN_BITS-1:0]     lo1_reg;
    sector_t                  sector1_reg;

    assign u       = REM_BITS'(REM_BITS'(SECTOR_SPAN) - weight);
    assign tu_next = TU_BITS'(t) * TU_BITS'(u);
    assign tc      = {1'b1, {FRACTION_BITS{1'b0}}} - {1'b0, t};
    assign lo_sum  = LO_BITS'(VALUE_MAX) * LO_BITS'(tc) + LO_HALF;

    // stage 2: mid numerator over 2^(F+10)
    logic [NW-1:0]       num;
    ctl_t                ctl2_reg;
    logic [MS_BITS-1:0]  ms2_reg;
    logic [CHAN_BITS-1:0] lo2_reg;
    sector_t             sector2_reg;

    assign num = K_NUM - NW'(VALUE_MAX) * NW'(tu_reg);

    // stage 3: divide by 15, estimate
    logic [RP_BITS-1:0]   recip_prod;
    ctl_t                 ctl3_reg;
    logic [MS_BITS-1:0]   ms3_reg;
    logic [CHAN_BITS-1:0] qest_reg;
    logic [CHAN_BITS-1:0] lo3_reg;
    sector_t              sector3_reg;

    assign recip_prod = RP_BITS'(ms2_reg) * RP_BITS'(RECIP_15);

    // stage 4: correct, order, black
    logic [MS_BITS-1:0]   diff;
    logic [CHAN_BITS-1:0] mid;
    logic [CHAN_BITS-1:0] hi;
    logic [CHAN_BITS-1:0] red_next;
    logic [CHAN_BITS-1:0] green_next;
    logic [CHAN_BITS-1:0] blue_next;
    logic                 valid_reg;
    logic [CHAN_BITS-1:0] red_reg;
    logic [CHAN_BITS-1:0] green_reg;
    logic [CHAN_BITS-1:0] blue_reg;

    assign diff = MS_BITS'(ms3_reg - MS_BITS'(qest_reg) * MS_BITS'(SECTOR_DIV));
    assign mid  = qest_reg + CHAN_BITS'(diff >= MS_BITS'(SECTOR_DIV));
    assign hi   = CHAN_BITS'(VALUE_MAX);

    always_comb
    begin
        case (sector3_reg)
            SECTOR_0:
            begin
                red_next = hi;      green_next = mid;     blue_next = lo3_reg;
            end
            SECTOR_1:
            begin
                red_next = mid;     green_next = hi;      blue_next = lo3_reg;
            end
            SECTOR_2:
            begin
                red_next = lo3_reg; green_next = hi;      blue_next = mid;
            end
            SECTOR_3:
            begin
                red_next = lo3_reg; green_next = mid;     blue_next = hi;
            end
            SECTOR_4:
            begin
                red_next = mid;     green_next = lo3_reg; blue_next = hi;
            end
            default:
            begin
                red_next = hi;      green_next = lo3_reg; blue_next = mid;
            end
        endcase
        if (ctl3_reg.black)
        begin
            red_next   = '0;
            green_next = '0;
            blue_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg  <= '0;
            ctl2_reg  <= '0;
            ctl3_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            ctl1_reg  <= in_ctl;
            ctl2_reg  <= ctl1_reg;
            ctl3_reg  <= ctl2_reg;
            valid_reg <= ctl3_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tu_reg      <= tu_next;
            lo1_reg     <= lo_sum[FRACTION_BITS +: CHAN_BITS];
            sector1_reg <= sector;
            ms2_reg     <= num[FRACTION_BITS + SECTOR_SHIFT +: MS_BITS];
            lo2_reg     <= lo1_reg;
            sector2_reg <= sector1_reg;
            ms3_reg     <= ms2_reg;
            qest_reg    <= recip_prod[RECIP_SHIFT +: CHAN_BITS];
            lo3_reg     <= lo2_reg;
            sector3_reg <= sector2_reg;
            red_reg     <= red_next;
            green_reg   <= green_next;
            blue_reg    <= blue_next;
        end
    end

    assign out_valid = valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

endmodule

// ----- rtl/iteration_to_hsv_color_top.sv -----
// Top level: iteration count to HSV-derived RGB pixel, fully pipelined.
//
//  channel  role    payload                      beat when
//  counts   sink    iteration_count              valid && ready
//  pixels   source  red, green, blue             valid && ready
//  cfg      sink    index, data                  valid && ready (ready tied high)
//
//  One beat per cycle in and out unless the output is stalled; the stages are the
//  one-bit-per-stage divider plus three hue and four channel stages.
//  All stages share one enable: they advance unless the output register holds
//  a beat that pixels is not taking; counts.ready follows that enable.
//  Reset clears the stage valid bits and sets limit 64, multiplier 1.
module iteration_to_hsv_color_top #(
    parameter int COUNT_BITS    = ithsv_pkg::COUNT_BITS_DEF,
    parameter int FRACTION_BITS = ithsv_pkg::FRACTION_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    ithsv_count_if.sink     counts,
    ithsv_pixel_if.source   pixels,
    ithsv_cfg_if.sink       cfg
);
    import ithsv_pkg::*;

    localparam logic [LIMIT_BITS-1:0] LIMIT_MASK =
        (COUNT_BITS >= LIMIT_BITS) ? {LIMIT_BITS{1'b1}}
                                   : LIMIT_BITS'((64'd1 << COUNT_BITS) - 64'd1);

    logic [LIMIT_BITS-1:0] limit_reg;
    logic [MULT_BITS-1:0]  mult_reg;
    logic                  en;

    ctl_t                     div_ctl;
    logic [FRACTION_BITS-1:0] div_t;
    ctl_t                     hue_ctl;
    logic [FRACTION_BITS-1:0] hue_t;
    sector_t                  hue_sector;
    logic [REM_BITS-1:0]      hue_weight;
    logic                     out_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET & LIMIT_MASK;
            mult_reg  <= MULT_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_ITERATION_LIMIT: limit_reg <= cfg.data[LIMIT_BITS-1:0] & LIMIT_MASK;
                CFG_HUE_MULTIPLIER:  mult_reg  <= cfg.data[MULT_BITS-1:0];
                default:             ;
            endcase
        end
    end

    assign cfg.ready    = 1'b1;
    assign en           = !out_valid || pixels.ready;
    assign counts.ready = en;
    assign pixels.valid = out_valid;

    ithsv_divider #(
        .COUNT_BITS    (COUNT_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (counts.valid),
        .count    (counts.iteration_count),
        .limit    (limit_reg),
        .out_ctl  (div_ctl),
        .quotient (div_t)
    );

    ithsv_hue #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_hue (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_ctl  (div_ctl),
        .t       (div_t),
        .mult    (mult_reg),
        .out_ctl (hue_ctl),
        .t_out   (hue_t),
        .sector  (hue_sector),
        .weight  (hue_weight)
    );

    ithsv_channel #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_channel (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_ctl    (hue_ctl),
        .t         (hue_t),
        .sector    (hue_sector),
        .weight    (hue_weight),
        .out_valid (out_valid),
        .red       (pixels.red),
        .green     (pixels.green),
        .blue      (pixels.blue)
    );

endmodule

// ----- rtl/ithsv_checker.sv -----
// Port checker for the iteration to HSV color top level, with its bind.
`include "iteration_to_hsv_color_top_assert.svh"

module ithsv_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [ithsv_pkg::CHAN_BITS-1:0] red,
    input logic [ithsv_pkg::CHAN_BITS-1:0] green,
    input logic [ithsv_pkg::CHAN_BITS-1:0] blue
);
    import ithsv_pkg::*;

    localparam logic [CHAN_BITS-1:0] HI = CHAN_BITS'(VALUE_MAX);

    logic [3*CHAN_BITS-1:0] pixel_word;
    logic                   stalled;
    logic                   is_black;
    logic                   has_hi;
    logic                   in_range;
    logic                   in_beat;

    assign pixel_word = {red, green, blue};
    assign stalled    = out_valid && !out_ready;
    assign is_black   = (red == '0) && (green == '0) && (blue == '0);
    assign has_hi     = (red == HI) || (green == HI) || (blue == HI);
    assign in_range   = (red <= HI) && (green <= HI) && (blue <= HI);
    assign in_beat    = in_valid && in_ready;

    `ITHSV_ASSERT_NEXT(a_out_valid_held, clk, rst_n, stalled, out_valid)
    `ITHSV_ASSERT_NEXT(a_out_payload_held, clk, rst_n, stalled, $stable(pixel_word))
    `ITHSV_ASSERT_NOW(a_ready_unless_stalled, clk, rst_n, !stalled, in_ready)
    `ITHSV_ASSERT_NOW(a_pixel_has_peak, clk, rst_n, out_valid, (is_black || has_hi) && in_range)
    `ITHSV_ASSERT_NOW(a_in_beat_not_stalled, clk, rst_n, in_beat, !stalled)

endmodule

bind iteration_to_hsv_color_top ithsv_checker u_ithsv_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (counts.valid),
    .in_ready  (counts.ready),
    .out_valid (pixels.valid),
    .out_ready (pixels.ready),
    .red       (pixels.red),
    .green     (pixels.green),
    .blue      (pixels.blue)
);
